// ----- src/lap_pkg.sv -----
// ----------------------------------------------------------------------------
// lap_pkg: shared types and constants of the 3x3 laplacian edge filter
// mask coefficients, register indexes and arithmetic widths
// ----------------------------------------------------------------------------
package lap_pkg;

   // arithmetic widths
   localparam int PIX_W   = 8;
   localparam int COEF_W  = 5;
   localparam int TERM_W  = 12;
   localparam int SUM_W   = 13;
   localparam int CSR_W   = 11;

   typedef logic signed [COEF_W-1:0] lap_coef_type;
   typedef logic signed [TERM_W-1:0] lap_term_type;
   typedef logic signed [SUM_W-1:0]  lap_sum_type;

   // register indexes of the write port
   localparam logic CSR_MASK_SELECT = 1'b0;
   localparam logic CSR_IMAGE_WIDTH = 1'b1;

   // register reset values
   localparam logic [1:0]       MASK_SELECT_RST = 2'd0;
   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RST = 11'd640;

   // row counter value at which a full window exists
   localparam logic [1:0] ROW_FULL = 2'd2;

   // masks, window index = row * 3 + column, row 0 oldest line
   localparam lap_coef_type MASK_TABLE [4][9] = '{
      '{ 5'sd0,  -5'sd1,  5'sd0, -5'sd1,  5'sd4, -5'sd1,  5'sd0, -5'sd1,  5'sd0 },
      '{ 5'sd0,   5'sd1,  5'sd0,  5'sd1, -5'sd4,  5'sd1,  5'sd0,  5'sd1,  5'sd0 },
      '{ -5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1 },
      '{ 5'sd1,  -5'sd2,  5'sd1, -5'sd2,  5'sd4, -5'sd2,  5'sd1, -5'sd2,  5'sd1 }
   };

   function automatic lap_coef_type lap_coef(input logic [1:0] sel, input logic [3:0] idx);
      return MASK_TABLE[sel][idx];
   endfunction

endpackage

// ----- src/lap_cell.sv -----
// ----------------------------------------------------------------------------
// lap_cell: one window cell
// holds one pixel, takes its neighbor's pixel on shift and weights it
// ----------------------------------------------------------------------------
module lap_cell (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [lap_pkg::PIX_W-1:0]  pixel_in,
   input  lap_pkg::lap_coef_type      coef,
   output logic [lap_pkg::PIX_W-1:0]  pixel_out,
   output lap_pkg::lap_term_type      term
);

   logic [lap_pkg::PIX_W-1:0] pixel_ff;
   logic signed [13:0]        prod;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pixel_ff <= pixel_in;
      end
   end

   // pixel times small signed coefficient, fits in the term width
   assign prod      = $signed({6'b0, pixel_ff}) * $signed({{9{coef[4]}}, coef});
   assign term      = prod[lap_pkg::TERM_W-1:0];
   assign pixel_out = pixel_ff;

endmodule

// ----- src/lap_line_store.sv -----
// ----------------------------------------------------------------------------
// lap_line_store: the two line stores as one memory
// entry holds {line r-1, line r-2}, registered read with write bypass
// ----------------------------------------------------------------------------
module lap_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_ff;
   logic [15:0] byp_data_ff;
   logic        byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // same-address write in the read cycle wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

// ----- src/laplacian_edge_3x3.sv -----
// ----------------------------------------------------------------------------
// laplacian_edge_3x3: streaming 3x3 laplacian edge filter
// 8-bit grayscale pixels in raster order, one edge word out per pixel in
// ----------------------------------------------------------------------------
// usage
// - req channel: one pixel word per handshake, req_tuser marks the first
//   pixel of a frame and restarts column and row counting
// - rsp channel: one word per accepted pixel, in order; edge value for the
//   window centered one row and one column back, rsp_tuser high when a full
//   3x3 window existed (border results carry zero and rsp_tuser low)
// - csr port: write-only, index 0 mask select, index 1 image width; write
//   only while no word is in flight
// - throughput: one pixel per clock while rsp is not stalled, set by the
//   single-port-per-cycle line store read and the window cell row shifting
//   once per pixel; an accepted pixel reaches rsp_tvalid through the line
//   store read, window shift, row sums, then output register
// - reset: counters, pipeline and output cleared, mask select 0, width 640;
//   line store contents are undefined until written, which only border
//   words depend on
// - stall: the whole pipe holds while rsp is stalled; a one-word input skid
//   keeps req_tready a register output, so one more word is taken
// ----------------------------------------------------------------------------
module laplacian_edge_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] pixel
   input  logic                          req_tuser,   // [0] frame_start
   // edge output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] edge_value
   output logic                          rsp_tuser,   // [0] window_valid
   // register writes
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [lap_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = (AW + 1 > lap_pkg::CSR_W) ? AW + 1 : lap_pkg::CSR_W;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
   localparam logic [WW-1:0] MIN_W = WW'(3);

   // configuration registers
   logic [1:0]               mask_select_ff;
   logic [lap_pkg::CSR_W-1:0] image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_select_ff <= lap_pkg::MASK_SELECT_RST;
         image_width_ff <= lap_pkg::IMAGE_WIDTH_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            lap_pkg::CSR_MASK_SELECT: mask_select_ff <= csr_wdata[1:0];
            lap_pkg::CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective width, clamped to 3..MAX_WIDTH
   logic [WW-1:0] img_w;
   logic [WW-1:0] width_eff;

   assign img_w     = WW'(image_width_ff);
   assign width_eff = (img_w < MIN_W) ? MIN_W : ((img_w > MAX_W) ? MAX_W : img_w);

   // pipe advance: the output register is free or being emptied
   logic en;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || rsp_tready;

   // input skid, holds one word when the pipe stalls
   logic       skid_valid_ff;
   logic [7:0] skid_pix_ff;
   logic       skid_fs_ff;
   logic       in_valid;
   logic [7:0] in_pix;
   logic       in_fs;
   logic       take;

   assign req_tready = !skid_valid_ff;
   assign in_valid   = skid_valid_ff || req_tvalid;
   assign in_pix     = skid_valid_ff ? skid_pix_ff : req_tdata;
   assign in_fs      = skid_valid_ff ? skid_fs_ff : req_tuser;
   assign take       = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_tvalid && req_tready) begin
         skid_pix_ff <= req_tdata;
         skid_fs_ff  <= req_tuser;
      end
   end

   // stage 0: position counters and line store read
   logic [AW-1:0] col_ff;
   logic [AW-1:0] col_in;
   logic [1:0]    row_ff;
   logic [1:0]    row_in;
   logic [AW-1:0] col_s0;
   logic [1:0]    row_s0;
   logic [WW-1:0] col_nx;
   logic          wrap;
   logic          win_s0;

   assign col_s0 = in_fs ? '0 : col_ff;
   assign row_s0 = in_fs ? 2'd0 : row_ff;
   assign col_nx = WW'(col_s0) + WW'(1);
   assign wrap   = (col_nx >= width_eff);
   assign win_s0 = (row_s0 == lap_pkg::ROW_FULL) && (col_s0 >= AW'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         col_in = wrap ? '0 : col_nx[AW-1:0];
         row_in = (wrap && row_s0 != lap_pkg::ROW_FULL) ? row_s0 + 2'd1 : row_s0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= 2'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store data back, store write and window shift
   logic          s1_v_ff;
   logic          s1_win_ff;
   logic [7:0]    s1_pix_ff;
   logic [AW-1:0] s1_col_ff;
   logic [15:0]   ls_rd;
   logic [7:0]    ls_upper;
   logic [7:0]    ls_lower;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_win_ff <= win_s0;
         s1_pix_ff <= in_pix;
         s1_col_ff <= col_s0;
      end
   end

   lap_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (col_s0),
      .rd_data (ls_rd),
      .wr_en   (en && s1_v_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_pix_ff, ls_lower})
   );

   // entry layout {line r-1, line r-2}; lower moves up, new pixel goes lower
   assign ls_upper = ls_rd[7:0];
   assign ls_lower = ls_rd[15:8];

   // window: three rows of three cells, column 2 newest
   logic [7:0]            row_feed [3];
   logic [7:0]            win_pix  [3][3];
   lap_pkg::lap_term_type win_term [3][3];
   logic                  shift_en;

   assign shift_en    = en && s1_v_ff;
   assign row_feed[0] = ls_upper;
   assign row_feed[1] = ls_lower;
   assign row_feed[2] = s1_pix_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         logic [7:0] feed;
         if (c == 2) begin : g_head
            assign feed = row_feed[r];
         end else begin : g_link
            assign feed = win_pix[r][c+1];
         end
         lap_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .pixel_in  (feed),
            .coef      (lap_pkg::lap_coef(mask_select_ff, 4'(r * 3 + c))),
            .pixel_out (win_pix[r][c]),
            .term      (win_term[r][c])
         );
      end
   end

   // stage 2: per-row sums of the weighted cells
   logic                 s2_v_ff;
   logic                 s2_win_ff;
   logic                 s3_v_ff;
   logic                 s3_win_ff;
   lap_pkg::lap_sum_type rsum_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_win_ff <= s1_win_ff;
         s3_win_ff <= s2_win_ff;
         for (int r = 0; r < 3; r++) begin
            rsum_ff[r] <= lap_pkg::SUM_W'(win_term[r][0]) + lap_pkg::SUM_W'(win_term[r][1])
                        + lap_pkg::SUM_W'(win_term[r][2]);
         end
      end
   end

   // stage 3: total, clamp to 0..255, output register
   lap_pkg::lap_sum_type total;
   logic [7:0]           sat;
   logic [7:0]           rsp_edge_ff;
   logic                 rsp_win_ff;

   assign total = rsum_ff[0] + rsum_ff[1] + rsum_ff[2];

   always_comb begin
      if (total[lap_pkg::SUM_W-1]) begin
         sat = 8'd0;
      end else if (total > lap_pkg::lap_sum_type'(255)) begin
         sat = 8'd255;
      end else begin
         sat = total[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_edge_ff <= s3_win_ff ? sat : 8'd0;
         rsp_win_ff  <= s3_win_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_edge_ff;
   assign rsp_tuser  = rsp_win_ff;

`ifndef SYNTHESIS
   // border words never carry an edge value
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("border word with nonzero edge value");

   // row counter saturates at a full window
   a_row_sat: assert property (@(posedge clock) disable iff (reset)
      row_ff == 2'd0 || row_ff == 2'd1 || row_ff == lap_pkg::ROW_FULL)
      else $error("row counter out of range");

   // a frame start restarts the line at column zero
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      take && in_fs |=> col_ff == AW'(1) && row_ff == 2'd0)
      else $error("frame start did not restart position");

   // the column stays inside the line store
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < MAX_W)
      else $error("column beyond line store depth");

   // a stalled pipe shifts no cells and writes no line store entry
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |-> !shift_en && !take)
      else $error("pipe moved during stall");
`endif

endmodule
